[rtl/csl_pkg.sv]
// Shared widths, constants, codes and the sequencer state type of the
// curvature speed limiter. No dependencies.
package csl_pkg;

  localparam int CURV_W    = 25;
  localparam int MAG_W     = 24;
  localparam int SPEED_W   = 16;
  localparam int REASON_W  = 2;
  localparam int CFG_IDX_W = 1;

  // Division K / m: quotient fits 29 bits since m > STRAIGHT_MAX.
  localparam int DIV_STEPS  = 29;
  localparam int SQRT_STEPS = 15;
  localparam int CNT_W      = 5;
  localparam int RAD_W      = 2 * SQRT_STEPS;
  localparam int ROOT_W     = SQRT_STEPS;
  localparam int SUB_W      = 25;

  localparam logic [38:0] GRIP_K = 39'd345158690191;
  localparam logic [DIV_STEPS-1:0] GRIP_K_LO = GRIP_K[DIV_STEPS-1:0];
  localparam logic [MAG_W-1:0] GRIP_K_HI = MAG_W'(GRIP_K >> DIV_STEPS);

  localparam logic [MAG_W-1:0] STRAIGHT_MAX     = 24'd1048;
  localparam logic [MAG_W-1:0] SMALL_CHANGE_MAX = 24'd10485;
  localparam logic [MAG_W-1:0] MAG_MAX          = 24'hFFFFFF;

  // x / 5 == (x * 419431) >> 21 for x < 699050
  localparam int FILT_W     = 19;
  localparam int PROD_W     = 2 * FILT_W;
  localparam int RECIP_SH   = 21;
  localparam logic [FILT_W-1:0] RECIP_5 = 19'd419431;

  localparam logic [SPEED_W-1:0] SPEED_LIMIT_RST = 16'd7680;
  localparam logic [SPEED_W-1:0] MIN_SPEED_RST   = 16'd5120;

  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED   = 1'd1;

  localparam logic [REASON_W-1:0] REASON_STRAIGHT = 2'd0;
  localparam logic [REASON_W-1:0] REASON_HELD     = 2'd1;
  localparam logic [REASON_W-1:0] REASON_FILTERED = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQRT,
    ST_FILT,
    ST_SCALE,
    ST_OUT
  } csl_state_t;

endpackage

[rtl/csl_in_if.sv]
// Input channel of the curvature speed limiter: valid/ready plus curvature.
// Depends on csl_pkg.
interface csl_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [csl_pkg::CURV_W-1:0] curvature;

  modport source (output valid, output curvature, input ready);
  modport sink   (input valid, input curvature, output ready);
endinterface

[rtl/csl_out_if.sv]
// Result channel of the curvature speed limiter: valid/ready, speed, reason.
// Depends on csl_pkg.
interface csl_out_if;
  logic                         valid;
  logic                         ready;
  logic [csl_pkg::SPEED_W-1:0]  speed;
  logic [csl_pkg::REASON_W-1:0] reason;

  modport source (output valid, output speed, output reason, input ready);
  modport sink   (input valid, input speed, input reason, output ready);
endinterface

[rtl/curvature_speed_limiter.sv]
// Curvature speed limiter top level: sequencer, shared subtractor for the
// restoring divide and square root, low-pass filter and output register.
// Depends on csl_pkg, csl_in_if, csl_out_if.
//
// Usage:
//   in_ch carries one signed Q4.20 curvature per item; out_ch returns one
//   item per input: speed (Q8.8) and reason (straight, held, filtered).
//   cfg_we/cfg_index/cfg_wdata write speed_limit (0) and min_speed (1);
//   write them only while the block is idle.
// Sequencing:
//   Straight and small-change items go from idle to the output state ST_OUT
//   and then to out_ch. Filtered items take 29 divide steps and 15 square-root
//   steps on one shared 25-bit subtractor, then the multiply state ST_FILT,
//   the scale state ST_SCALE and the output load in ST_OUT. The next item is
//   taken once the sequencer is back in idle; in_ch.ready is high only while
//   the sequencer is idle, so one item is in work at a time.
// Reset:
//   Synchronous active-low rst_n clears the sequencer, the output valid, the
//   stored curvature and the primed flag, and restores the register defaults.
// Stall:
//   The output register holds a finished item while out_ch.ready is low; the
//   block still accepts and works one more item, which then waits for the
//   output register to free.
module curvature_speed_limiter (
  input  logic                                 clk,
  input  logic                                 rst_n,
  csl_in_if.sink                               in_ch,
  csl_out_if.source                            out_ch,
  input  logic                                 cfg_we,
  input  logic [csl_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [csl_pkg::SPEED_W-1:0]          cfg_wdata
);

  csl_pkg::csl_state_t state_r, state_nxt;

  logic [csl_pkg::SPEED_W-1:0]   speed_limit_r, min_speed_r;
  logic [csl_pkg::MAG_W-1:0]     last_curv_r;
  logic [csl_pkg::SPEED_W-1:0]   held_r;
  logic                          primed_r;

  logic [csl_pkg::MAG_W-1:0]     rem_r;
  logic [csl_pkg::RAD_W-1:0]     quo_r;
  logic [csl_pkg::ROOT_W-1:0]    root_r;
  logic [csl_pkg::CNT_W-1:0]     cnt_r;
  logic [csl_pkg::PROD_W-2:0]    prod_r;
  logic [csl_pkg::SPEED_W-1:0]   res_speed_r;
  logic [csl_pkg::REASON_W-1:0]  res_reason_r;

  logic                          out_valid_r;
  logic [csl_pkg::SPEED_W-1:0]   out_speed_r;
  logic [csl_pkg::REASON_W-1:0]  out_reason_r;

  logic                          accept;
  logic                          out_load;
  logic                          in_ready;
  logic                          step_done;

  // magnitude and change at acceptance
  logic [csl_pkg::CURV_W-1:0]    abs_curv;
  logic [csl_pkg::MAG_W-1:0]     mag;
  logic [csl_pkg::MAG_W-1:0]     mag_diff;
  logic                          straight;
  logic                          small_change;
  logic [csl_pkg::SPEED_W-1:0]   held_eff;

  // shared subtractor
  logic [csl_pkg::SUB_W-1:0]     sub_a, sub_b;
  logic [csl_pkg::SUB_W:0]       sub_res;
  logic                          sub_ge;
  logic [csl_pkg::SUB_W-1:0]     div_sh;
  logic [17:0]                   sqrt_sh;

  // filter
  logic [csl_pkg::SPEED_W-1:0]   clamp_hi, clamp_lo;
  logic [csl_pkg::FILT_W-1:0]    filt_sum;
  logic [csl_pkg::PROD_W-1:0]    filt_prod;

  assign accept   = in_ch.valid && in_ready;
  assign out_load = (state_r == csl_pkg::ST_OUT) && (!out_valid_r || out_ch.ready);

  assign abs_curv = in_ch.curvature[csl_pkg::CURV_W-1] ?
                    csl_pkg::CURV_W'(-in_ch.curvature) : in_ch.curvature;
  assign mag      = abs_curv[csl_pkg::CURV_W-1] ? csl_pkg::MAG_MAX
                                                : abs_curv[csl_pkg::MAG_W-1:0];
  assign mag_diff = (mag >= last_curv_r) ? mag - last_curv_r : last_curv_r - mag;
  assign straight     = mag <= csl_pkg::STRAIGHT_MAX;
  assign small_change = mag_diff <= csl_pkg::SMALL_CHANGE_MAX;
  assign held_eff     = primed_r ? held_r : speed_limit_r;

  assign div_sh  = {rem_r, csl_pkg::GRIP_K_LO[cnt_r]};
  assign sqrt_sh = {rem_r[15:0], quo_r[csl_pkg::RAD_W-1 -: 2]};

  always_comb begin
    if (state_r == csl_pkg::ST_SQRT) begin
      sub_a = csl_pkg::SUB_W'(sqrt_sh);
      sub_b = csl_pkg::SUB_W'({root_r, 2'b01});
    end else begin
      sub_a = div_sh;
      sub_b = {1'b0, last_curv_r};
    end
  end

  assign sub_res = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge  = !sub_res[csl_pkg::SUB_W];

  assign clamp_hi  = ({1'b0, root_r} > speed_limit_r) ? speed_limit_r : {1'b0, root_r};
  assign clamp_lo  = (clamp_hi < min_speed_r) ? min_speed_r : clamp_hi;
  assign filt_sum  = csl_pkg::FILT_W'(clamp_lo) + {1'b0, held_r, 2'b00}
                     + csl_pkg::FILT_W'(2);
  assign filt_prod = filt_sum * csl_pkg::RECIP_5;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      csl_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = (straight || small_change) ? csl_pkg::ST_OUT : csl_pkg::ST_DIV;
        end
      end
      csl_pkg::ST_DIV: begin
        if (step_done) state_nxt = csl_pkg::ST_SQRT;
      end
      csl_pkg::ST_SQRT: begin
        if (step_done) state_nxt = csl_pkg::ST_FILT;
      end
      csl_pkg::ST_FILT:  state_nxt = csl_pkg::ST_SCALE;
      csl_pkg::ST_SCALE: state_nxt = csl_pkg::ST_OUT;
      csl_pkg::ST_OUT: begin
        if (!out_valid_r || out_ch.ready) state_nxt = csl_pkg::ST_IDLE;
      end
      default: state_nxt = csl_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = rst_n && (state_r == csl_pkg::ST_IDLE);
    step_done = (cnt_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= csl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_limit_r <= csl_pkg::SPEED_LIMIT_RST;
      min_speed_r   <= csl_pkg::MIN_SPEED_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        csl_pkg::CFG_SPEED_LIMIT: speed_limit_r <= cfg_wdata;
        csl_pkg::CFG_MIN_SPEED:   min_speed_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // item state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_curv_r <= '0;
      primed_r    <= 1'b0;
    end else if (accept) begin
      last_curv_r <= mag;
      primed_r    <= 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      csl_pkg::ST_IDLE: begin
        if (accept) begin
          rem_r <= csl_pkg::GRIP_K_HI;
          quo_r <= '0;
          cnt_r <= csl_pkg::CNT_W'(csl_pkg::DIV_STEPS - 1);
          if (straight) begin
            held_r       <= speed_limit_r;
            res_speed_r  <= speed_limit_r;
            res_reason_r <= csl_pkg::REASON_STRAIGHT;
          end else begin
            held_r       <= held_eff;
            res_speed_r  <= held_eff;
            res_reason_r <= csl_pkg::REASON_HELD;
          end
        end
      end
      csl_pkg::ST_DIV: begin
        quo_r <= {quo_r[csl_pkg::RAD_W-2:0], sub_ge};
        if (step_done) begin
          rem_r  <= '0;
          cnt_r  <= csl_pkg::CNT_W'(csl_pkg::SQRT_STEPS - 1);
          root_r <= '0;
        end else begin
          rem_r <= sub_ge ? sub_res[csl_pkg::MAG_W-1:0] : div_sh[csl_pkg::MAG_W-1:0];
          cnt_r <= cnt_r - 1'b1;
        end
      end
      csl_pkg::ST_SQRT: begin
        if (step_done) begin
          rem_r <= '0;
        end else begin
          rem_r <= sub_ge ? sub_res[csl_pkg::MAG_W-1:0] : csl_pkg::MAG_W'(sqrt_sh);
        end
        quo_r  <= {quo_r[csl_pkg::RAD_W-3:0], 2'b00};
        root_r <= {root_r[csl_pkg::ROOT_W-2:0], sub_ge};
        cnt_r  <= cnt_r - 1'b1;
      end
      csl_pkg::ST_FILT: begin
        prod_r <= filt_prod[csl_pkg::PROD_W-2:0];
      end
      csl_pkg::ST_SCALE: begin
        res_speed_r  <= prod_r[csl_pkg::RECIP_SH +: csl_pkg::SPEED_W];
        held_r       <= prod_r[csl_pkg::RECIP_SH +: csl_pkg::SPEED_W];
        res_reason_r <= csl_pkg::REASON_FILTERED;
      end
      csl_pkg::ST_OUT: ;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_speed_r  <= res_speed_r;
      out_reason_r <= res_reason_r;
    end
  end

  assign in_ch.ready   = in_ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.speed  = out_speed_r;
  assign out_ch.reason = out_reason_r;

endmodule
